[rtl/gfpa_pkg.sv]
// Shared types, constants and field arithmetic for the GF(16) polynomial unit.
package gfpa_pkg;

    typedef enum logic [2:0] {
        OP_SCALE  = 3'd0,
        OP_MUL    = 3'd1,
        OP_REM    = 3'd2,
        OP_EVAL   = 3'd3,
        OP_DERIV  = 3'd4,
        OP_DIV    = 3'd5
    } t_op;

    localparam logic [4:0] FIELD_POLY = 5'b10011;

    // Multiply two field elements modulo x^4+x+1.
    function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] acc;
        logic [3:0] sh;
        acc = 4'd0;
        sh  = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) acc = acc ^ sh;
            sh = sh[3] ? ((sh << 1) ^ FIELD_POLY[3:0]) : (sh << 1);
        end
        return acc;
    endfunction

    // Inverse table; entry 0 is unused.
    function automatic logic [3:0] gf_inv(input logic [3:0] b);
        logic [3:0] r;
        case (b)
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd9;
            4'd3:    r = 4'd14;
            4'd4:    r = 4'd13;
            4'd5:    r = 4'd11;
            4'd6:    r = 4'd7;
            4'd7:    r = 4'd6;
            4'd8:    r = 4'd15;
            4'd9:    r = 4'd2;
            4'd10:   r = 4'd12;
            4'd11:   r = 4'd5;
            4'd12:   r = 4'd10;
            4'd13:   r = 4'd4;
            4'd14:   r = 4'd3;
            4'd15:   r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/gfpa_lane.sv]
// One multiply-accumulate lane: acc_out = acc_in ^ x * y over GF(16).
module gfpa_lane (
    input  logic [3:0] i_acc,
    input  logic [3:0] i_x,
    input  logic [3:0] i_y,
    output logic [3:0] o_acc
);
    assign o_acc = i_acc ^ gfpa_pkg::gf_mul(i_x, i_y);
endmodule

[rtl/gf16_poly_arith_unit.sv]
// Top level of the GF(16) polynomial arithmetic unit: lanes, sequencer and output register.
//
//   channel | direction | handshake         | payload
//   input   | in        | i_valid / o_stall | operation, poly_a, poly_b, a_terms, b_terms,
//           |           |                   | elem_a, elem_b
//   output  | out       | o_valid / i_stall | result_poly, result_elem, error
//
// Derivative and divide go from acceptance straight to the done state; scale takes one lane step.
// Multiply takes one lane step per coefficient of a over all TERMS coefficients, reusing the row
// of TERMS lanes; remainder takes one lane step per dividend term; evaluate one Horner step per term.
// One word is in work at a time; a finished word moves to the output register once that is
// free, so the next word can be accepted while a result waits under output stall.
// Reset is synchronous, active low.
module gf16_poly_arith_unit #(
    parameter int TERMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_poly_a,
    input  logic [63:0] i_poly_b,
    input  logic [4:0]  i_a_terms,
    input  logic [4:0]  i_b_terms,
    input  logic [3:0]  i_elem_a,
    input  logic [3:0]  i_elem_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_poly,
    output logic [3:0]  o_result_elem,
    output logic        o_error
);
    localparam int CW = $clog2(TERMS + 1);
    localparam int IW = $clog2(TERMS);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state            r_state;
    gfpa_pkg::t_op     r_op;
    logic [3:0]        r_a [TERMS];
    logic [3:0]        r_b [TERMS];
    logic [3:0]        r_r [TERMS];
    logic [3:0]        r_eb;
    logic [3:0]        r_e;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_nb;
    logic              r_err;
    logic              r_ovalid;
    logic [63:0]       r_opoly;
    logic [3:0]        r_oelem;
    logic              r_oerr;

    t_state            n_state;
    logic [CW-1:0]     n_cnt;
    logic              n_err;
    logic [3:0]        n_e;
    logic [3:0]        n_r [TERMS];

    logic [3:0] w_x  [TERMS];
    logic [3:0] w_y  [TERMS];
    logic [3:0] w_ai [TERMS];
    logic [3:0] w_ao [TERMS];
    logic [3:0] w_top;
    logic [5:0] w_sum;
    logic [63:0] w_pack;
    logic [63:0] w_amask;
    logic [63:0] w_ashift;
    logic        w_load;

    logic accept;
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // The finished word moves out once the output register is empty or being taken.
    assign w_load = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    // Current top coefficient of the remainder window.
    assign w_top = r_r[r_cnt[IW-1:0]];

    generate
        for (genvar k = 0; k < TERMS; k++) begin : g_lane
            always_comb begin
                w_x[k]  = 4'd0;
                w_y[k]  = 4'd0;
                w_ai[k] = r_r[k];
                case (r_op)
                    gfpa_pkg::OP_SCALE: begin
                        w_x[k] = r_a[k]; w_y[k] = r_eb; w_ai[k] = 4'd0;
                    end
                    gfpa_pkg::OP_MUL: begin
                        // step i adds a[i]*b[k-i]
                        if (k >= int'(r_cnt)) begin
                            w_x[k] = r_a[r_cnt[IW-1:0]];
                            w_y[k] = r_b[IW'(k - int'(r_cnt))];
                        end
                    end
                    gfpa_pkg::OP_REM: begin
                        if (k <= int'(r_cnt) && k + int'(r_nb) > int'(r_cnt)) begin
                            w_x[k] = w_top;
                            w_y[k] = r_b[IW'(k + int'(r_nb) - 1 - int'(r_cnt))];
                        end
                    end
                    default: ;
                endcase
            end
            gfpa_lane u_lane (.i_acc(w_ai[k]), .i_x(w_x[k]), .i_y(w_y[k]), .o_acc(w_ao[k]));
        end
    endgenerate

    always_comb begin
        w_pack = '0;
        for (int k = 0; k < TERMS; k++) w_pack[4*k +: 4] = r_r[k];
    end

    assign w_sum = {1'b0, i_a_terms} + {1'b0, i_b_terms};

    // Dividend terms below a_terms, moved up by b_terms-1 places into the remainder window.
    always_comb begin
        w_amask = '0;
        for (int k = 0; k < 16; k++)
            if (k < int'(i_a_terms)) w_amask[4*k +: 4] = i_poly_a[4*k +: 4];
    end
    assign w_ashift = w_amask << {i_b_terms - 5'd1, 2'b00};

    // Working state loaded when a word is accepted.
    always_comb begin
        n_state = S_DONE;
        n_cnt   = '0;
        n_err   = 1'b0;
        n_e     = 4'd0;
        for (int k = 0; k < TERMS; k++) n_r[k] = 4'd0;
        case (gfpa_pkg::t_op'(i_operation))
            gfpa_pkg::OP_SCALE: n_state = S_RUN;
            gfpa_pkg::OP_MUL:   n_state = S_RUN;
            gfpa_pkg::OP_REM: begin
                if (i_a_terms == 5'd0 || i_b_terms == 5'd0 ||
                    w_sum - 6'd1 > 6'(TERMS)) begin
                    n_err = 1'b1;
                end else begin
                    for (int k = 0; k < TERMS; k++) n_r[k] = w_ashift[4*k +: 4];
                    n_cnt   = CW'(w_sum - 6'd2);
                    n_state = S_RUN;
                end
            end
            gfpa_pkg::OP_EVAL: begin
                n_cnt   = (i_a_terms > 5'(TERMS)) ? CW'(TERMS) : CW'(i_a_terms);
                n_state = S_RUN;
            end
            gfpa_pkg::OP_DERIV: begin
                for (int k = 0; k + 1 < TERMS; k++)
                    n_r[k] = (k % 2 == 0) ? i_poly_a[4*(k+1) +: 4] : 4'd0;
            end
            gfpa_pkg::OP_DIV: begin
                if (i_elem_b == 4'd0) n_err = 1'b1;
                else n_e = gfpa_pkg::gf_mul(i_elem_a, gfpa_pkg::gf_inv(i_elem_b));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= w_load || (r_ovalid && i_stall);
            case (r_state)
                S_IDLE: if (accept) begin
                    r_op  <= gfpa_pkg::t_op'(i_operation);
                    r_eb  <= i_elem_b;
                    r_nb  <= CW'(i_b_terms);
                    for (int k = 0; k < TERMS; k++) begin
                        r_a[k] <= i_poly_a[4*k +: 4];
                        r_b[k] <= i_poly_b[4*k +: 4];
                        r_r[k] <= n_r[k];
                    end
                    r_e     <= n_e;
                    r_err   <= n_err;
                    r_cnt   <= n_cnt;
                    r_state <= n_state;
                end
                S_RUN: begin
                    case (r_op)
                        gfpa_pkg::OP_SCALE: begin
                            for (int k = 0; k < TERMS; k++) r_r[k] <= w_ao[k];
                            r_state <= S_DONE;
                        end
                        gfpa_pkg::OP_MUL: begin
                            for (int k = 0; k < TERMS; k++) r_r[k] <= w_ao[k];
                            r_cnt <= r_cnt + 1'b1;
                            if (r_cnt == CW'(TERMS - 1)) r_state <= S_DONE;
                        end
                        gfpa_pkg::OP_REM: begin
                            for (int k = 0; k < TERMS; k++) r_r[k] <= w_ao[k];
                            if (r_cnt == r_nb - 1'b1) r_state <= S_DONE;
                            else r_cnt <= r_cnt - 1'b1;
                        end
                        gfpa_pkg::OP_EVAL: begin
                            if (r_cnt == '0) r_state <= S_DONE;
                            else begin
                                r_e <= gfpa_pkg::gf_mul(r_e, r_eb) ^
                                       r_a[IW'(r_cnt - 1'b1)];
                                r_cnt <= r_cnt - 1'b1;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_DONE: if (w_load) begin
                    r_oerr   <= r_err;
                    r_opoly  <= (r_err || r_op == gfpa_pkg::OP_EVAL || r_op == gfpa_pkg::OP_DIV
                                 || r_op > gfpa_pkg::OP_DIV) ? 64'd0 : w_pack;
                    r_oelem  <= (r_op == gfpa_pkg::OP_EVAL || r_op == gfpa_pkg::OP_DIV)
                                ? r_e : 4'd0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_result_poly = r_opoly;
    assign o_result_elem = r_oelem;
    assign o_error       = r_oerr;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_opoly)))
        else $error("result lost under stall");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oerr) |-> (r_opoly == 64'd0 && r_oelem == 4'd0))
        else $error("error result not cleared");
endmodule

[bench/tb_gf16_poly_arith_unit.sv]
// Self-checking testbench for the GF(16) polynomial arithmetic unit.
module tb_gf16_poly_arith_unit;

    localparam int NTERMS    = 16;
    localparam int N_RANDOM  = 1750;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] poly_a;
        logic [63:0] poly_b;
        logic [4:0]  a_terms;
        logic [4:0]  b_terms;
        logic [3:0]  elem_a;
        logic [3:0]  elem_b;
    } t_word_in;

    typedef struct packed {
        logic [63:0] result_poly;
        logic [3:0]  result_elem;
        logic        error;
    } t_word_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_operation;
    logic [63:0] i_poly_a;
    logic [63:0] i_poly_b;
    logic [4:0]  i_a_terms;
    logic [4:0]  i_b_terms;
    logic [3:0]  i_elem_a;
    logic [3:0]  i_elem_b;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_poly;
    logic [3:0]  o_result_elem;
    logic        o_error;

    gf16_poly_arith_unit #(.TERMS(NTERMS)) u_dut (.*);

    t_word_in  pending_words[$];
    t_word_out expected_results[$];
    int        mismatches;
    int        cycle_count;
    bit        stimulus_done;
    bit        hold_sink;
    int        sink_hold_cycles;
    int        sender_wait;
    int        sink_wait;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Field multiply by shift and add, reducing by x^4+x+1.
    function automatic logic [3:0] field_mul(logic [3:0] x, logic [3:0] y);
        logic [3:0] acc;
        logic [4:0] sh;
        acc = 4'd0;
        sh = {1'b0, x};
        for (int i = 0; i < 4; i++) begin
            if (y[i]) acc ^= sh[3:0];
            sh = sh << 1;
            if (sh[4]) sh ^= 5'b10011;
        end
        return acc;
    endfunction

    function automatic t_word_out gf_poly_result(t_word_in w);
        t_word_out  res;
        logic [3:0] a[32];
        logic [3:0] b[32];
        logic [3:0] r[32];
        logic [3:0] c;
        logic [3:0] inv;
        int         na;
        int         nb;
        int         base;
        res = '0;
        na = w.a_terms;
        nb = w.b_terms;
        for (int k = 0; k < 32; k++) begin
            a[k] = (k < NTERMS) ? w.poly_a[4*k +: 4] : 4'd0;
            b[k] = (k < NTERMS) ? w.poly_b[4*k +: 4] : 4'd0;
            r[k] = 4'd0;
        end
        case (w.operation)
            gfpa_pkg::OP_SCALE:
                for (int k = 0; k < NTERMS; k++) r[k] = field_mul(a[k], w.elem_b);
            gfpa_pkg::OP_MUL:
                for (int i = 0; i < NTERMS; i++)
                    for (int j = 0; i + j < NTERMS; j++) r[i+j] ^= field_mul(a[i], b[j]);
            gfpa_pkg::OP_REM:
                if (na == 0 || nb == 0 || na + nb - 1 > NTERMS) begin
                    res.error = 1'b1;
                end else begin
                    for (int k = 0; k < na; k++) r[k + nb - 1] = a[k];
                    // Terms of b beyond b_terms are not part of the divisor.
                    for (int t = na + nb - 2; t >= nb - 1; t--) begin
                        c = r[t];
                        base = t - (nb - 1);
                        for (int j = 0; j < nb; j++) r[base + j] ^= field_mul(b[j], c);
                    end
                end
            gfpa_pkg::OP_EVAL: begin
                if (na > NTERMS) na = NTERMS;
                for (int k = na - 1; k >= 0; k--)
                    res.result_elem = field_mul(res.result_elem, w.elem_b) ^ a[k];
            end
            gfpa_pkg::OP_DERIV:
                for (int k = 0; k + 1 < NTERMS; k++) r[k] = (k % 2 == 0) ? a[k+1] : 4'd0;
            gfpa_pkg::OP_DIV:
                if (w.elem_b == 4'd0) begin
                    res.error = 1'b1;
                end else begin
                    inv = 4'd1;
                    for (int i = 0; i < 14; i++) inv = field_mul(inv, w.elem_b);
                    res.result_elem = field_mul(w.elem_a, inv);
                end
            default: ;
        endcase
        if (w.operation inside {gfpa_pkg::OP_SCALE, gfpa_pkg::OP_MUL, gfpa_pkg::OP_REM,
                                gfpa_pkg::OP_DERIV} && !res.error)
            for (int k = 0; k < NTERMS; k++) res.result_poly[4*k +: 4] = r[k];
        return res;
    endfunction

    function automatic logic [63:0] rand_poly();
        return {$urandom, $urandom};
    endfunction

    // Remainder words mostly get valid sizes and a monic divisor.
    function automatic t_word_in rand_word();
        t_word_in w;
        w.operation = 3'($urandom_range(0, 7));
        w.poly_a = rand_poly();
        w.poly_b = rand_poly();
        w.a_terms = 5'($urandom);
        w.b_terms = 5'($urandom);
        w.elem_a = 4'($urandom);
        w.elem_b = 4'($urandom);
        if (w.operation == gfpa_pkg::OP_REM && $urandom_range(0, 9) < 8) begin
            w.b_terms = 5'($urandom_range(1, NTERMS));
            w.a_terms = 5'($urandom_range(1, NTERMS + 1 - w.b_terms));
            if ($urandom_range(0, 3) != 0) w.poly_b[4*(w.b_terms-1) +: 4] = 4'd1;
        end
        return w;
    endfunction

    function automatic t_word_in make_word(logic [2:0] op, logic [63:0] pa, logic [63:0] pb,
                                           int na, int nb, int ea, int eb);
        t_word_in w;
        w = '{op, pa, pb, 5'(na), 5'(nb), 4'(ea), 4'(eb)};
        return w;
    endfunction

    initial begin
        t_word_in w;
        i_rst_n = 1'b0;
        stimulus_done = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_words.push_back(make_word(gfpa_pkg::OP_SCALE, '1, '0, 16, 16, 0, 15));
        pending_words.push_back(make_word(gfpa_pkg::OP_SCALE, 64'h0123456789ABCDEF, '0,
                                          1, 1, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_MUL, '1, '1, 16, 16, 15, 15));
        pending_words.push_back(make_word(gfpa_pkg::OP_MUL, 64'h0000000000000012, 64'h31,
                                          0, 0, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, '1, '1, 16, 1, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, '1, '1, 1, 16, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, 64'h123, 64'h1F7, 3, 3, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, 64'h123, 64'h5F7, 3, 3, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, '1, '1, 0, 4, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, '1, '1, 4, 0, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, '1, '1, 9, 9, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_REM, '1, '1, 31, 31, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_EVAL, 64'hFEDCBA9876543210, '0,
                                          16, 0, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_EVAL, '1, '0, 0, 0, 0, 7));
        pending_words.push_back(make_word(gfpa_pkg::OP_EVAL, '1, '0, 31, 0, 0, 15));
        pending_words.push_back(make_word(gfpa_pkg::OP_EVAL, 64'h0123456789ABCDEF, '0,
                                          5, 0, 0, 2));
        pending_words.push_back(make_word(gfpa_pkg::OP_DERIV, '1, '0, 0, 0, 0, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_DIV, '0, '0, 0, 0, 9, 0));
        pending_words.push_back(make_word(gfpa_pkg::OP_DIV, '0, '0, 0, 0, 0, 5));
        pending_words.push_back(make_word(gfpa_pkg::OP_DIV, '0, '0, 0, 0, 15, 1));
        pending_words.push_back(make_word(gfpa_pkg::OP_DIV, '0, '0, 0, 0, 15, 15));
        pending_words.push_back(make_word(3'd6, '1, '1, 31, 31, 15, 15));
        pending_words.push_back(make_word(3'd7, '1, '1, 31, 31, 15, 15));

        wait (pending_words.size() == 0);
        // Let every directed result drain before the random part starts.
        wait (expected_results.size() == 0);
        for (int n = 0; n < N_RANDOM; n++) begin
            w = rand_word();
            pending_words.push_back(w);
            if (n == 300) begin
                // Long receiver hold while the sender keeps offering words.
                hold_sink = 1'b1;
                for (int k = 0; k < 20; k++) pending_words.push_back(rand_word());
                n += 20;
            end
            while (pending_words.size() > 8) @(posedge i_clk);
        end
        wait (pending_words.size() == 0 && !i_valid);
        stimulus_done = 1'b1;
    end

    // Sender: draws a gap per word, keeps valid and payload steady while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            {i_operation, i_poly_a, i_poly_b, i_a_terms, i_b_terms, i_elem_a, i_elem_b}
                <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                if (sender_wait == 0 && pending_words.size() > 0 &&
                    $urandom_range(0, 3) == 0) begin
                    {i_operation, i_poly_a, i_poly_b, i_a_terms, i_b_terms, i_elem_a, i_elem_b}
                        <= pending_words[0];
                    expected_results.push_back(gf_poly_result(pending_words.pop_front()));
                end else begin
                    i_valid <= 1'b0;
                    sender_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
                end
            end else if (!i_valid) begin
                if (sender_wait > 0) begin
                    sender_wait <= sender_wait - 1;
                end else if (pending_words.size() > 0) begin
                    i_valid <= 1'b1;
                    {i_operation, i_poly_a, i_poly_b, i_a_terms, i_b_terms, i_elem_a, i_elem_b}
                        <= pending_words[0];
                    expected_results.push_back(gf_poly_result(pending_words.pop_front()));
                end
            end
        end
    end

    // Receiver: checks accepted words and draws its own stall pattern.
    always @(posedge i_clk) begin
        t_word_out got;
        t_word_out want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_result_poly, o_result_elem, o_error};
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("Unexpected result word %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"Result mismatch: expected poly %h elem %h err %b,",
                                      " got poly %h elem %h err %b"},
                                     want.result_poly, want.result_elem, want.error,
                                     got.result_poly, got.result_elem, got.error);
                    end
                end
            end
            // The long hold runs once, starting when it is requested.
            if (hold_sink && sink_hold_cycles < 600) begin
                sink_hold_cycles <= sink_hold_cycles + 1;
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall) begin
                sink_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
                i_stall <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait <= sink_wait - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (!(stimulus_done && expected_results.size() == 0) && cycle_count < MAX_CYCLE) begin
            @(posedge i_clk);
            cycle_count++;
        end
        if (cycle_count >= MAX_CYCLE) begin
            $display("SCOREBOARD MISMATCH");
        end else begin
            repeat (40) @(posedge i_clk);
            if (mismatches == 0 && expected_results.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end
endmodule
